// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions with clock and reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on a named clock, disabled while the named reset is low.
`define TPL_ASSERT_CLK(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
        else $error("assertion lbl failed");

// Assert a property on clk with rst_n.
`define TPL_ASSERT(lbl, prop) \
    `TPL_ASSERT_CLK(lbl, clk, rst_n, prop)

`endif

// File: hdl/tpl_pkg.sv
// ---------------------------------------------------------------------------
// tpl_pkg
// Types and constants of the threshold perceptron layer.
// ---------------------------------------------------------------------------
package tpl_pkg;

    localparam int NEURONS   = 4;
    localparam int LINES     = 8;

    localparam int SIG_W     = 8;
    localparam int FIRED_W   = 4;
    localparam int VALUE_W   = 32;
    localparam int NIDX_IN_W = 4;
    localparam int LIDX_IN_W = 5;
    localparam int OP_W      = 2;
    localparam int COUNT_W   = 9;
    localparam int WIN_W     = 8;
    localparam int RATE_W    = 16;
    localparam int FRAC_W    = 16;

    localparam int NIDX_W    = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int SUM_W     = VALUE_W + $clog2(LINES) + 1;
    localparam int THR_W     = VALUE_W + FRAC_W;
    localparam int GAIN_W    = COUNT_W + RATE_W;
    localparam int PROD_W    = VALUE_W + GAIN_W + 1;
    localparam int QUO_W     = PROD_W - 1 - FRAC_W;
    localparam int QCNT_W    = $clog2(QUO_W + 1);
    localparam int DELTA_W   = QUO_W + 1;
    localparam int NEWW_W    = DELTA_W + 1;
    localparam int ACC_W     = (NEURONS > FIRED_W) ? NEURONS : FIRED_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam int REG_IDX_W = 1;
    localparam int CFG_W     = 16;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_RATE   = 1'd1;

    localparam logic [WIN_W-1:0]  WINDOW_RESET = 8'd5;
    localparam logic [RATE_W-1:0] RATE_RESET   = 16'd655;

    typedef enum logic [OP_W-1:0] {
        OP_STEP           = 2'd0,
        OP_LOAD_WEIGHT    = 2'd1,
        OP_LOAD_THRESHOLD = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD_GO,
        ST_UPD_WAIT,
        ST_SUM,
        ST_DRAIN,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_SCALE,
        CS_MUL,
        CS_MAG,
        CS_DIV,
        CS_APPLY
    } cell_state_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic                      count_en;
        logic                      clear;
        logic                      upd_start;
        logic                      load_en;
        logic [NIDX_W-1:0]         load_neuron;
        logic signed [VALUE_W-1:0] load_value;
        logic [WIN_W-1:0]          win;
        logic [RATE_W-1:0]         rate;
    } tpl_ctl_t;

    // Partial sum handed from cell to cell
    typedef struct packed {
        logic                    valid;
        logic [NIDX_W-1:0]       idx;
        logic signed [SUM_W-1:0] sum;
    } tpl_link_t;

endpackage

// File: hdl/tpl_channels.sv
// ---------------------------------------------------------------------------
// tpl_channels
// Valid/ready channels for command items and result items.
// ---------------------------------------------------------------------------
interface tpl_cmd_if;
    import tpl_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           opcode;
    logic [NIDX_IN_W-1:0]      neuron_index;
    logic [LIDX_IN_W-1:0]      line_index;
    logic signed [VALUE_W-1:0] load_value;
    logic [SIG_W-1:0]          signals;

    modport source (output valid, opcode, neuron_index, line_index, load_value, signals,
                    input ready);
    modport sink   (input valid, opcode, neuron_index, line_index, load_value, signals,
                    output ready);
endinterface

interface tpl_res_if;
    import tpl_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIRED_W-1:0] fired;
    logic               weights_updated;

    modport source (output valid, fired, weights_updated, input ready);
    modport sink   (input valid, fired, weights_updated, output ready);
endinterface

// File: hdl/tpl_cell.sv
// ---------------------------------------------------------------------------
// tpl_cell
// One input line: its ones count, its weights, a serial strengthening unit
// and one stage of the partial-sum chain.
// ---------------------------------------------------------------------------
module tpl_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  tpl_pkg::tpl_ctl_t  ctl,
    input  logic               wsel,
    input  logic               sig,
    input  tpl_pkg::tpl_link_t link_in,
    output tpl_pkg::tpl_link_t link_out,
    output logic               busy
);
    import tpl_pkg::*;

    cell_state_t               state_reg, state_next;
    logic [COUNT_W-1:0]        count_reg;
    logic                      sig_reg;
    logic signed [VALUE_W-1:0] w_reg [NEURONS];
    logic [NIDX_W-1:0]         nidx_reg, nidx_next;
    logic [GAIN_W-1:0]         gain_reg, gain_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic [QUO_W-1:0]          quo_reg, quo_next;
    logic [WIN_W-1:0]          rem_reg, rem_next;
    logic                      neg_reg, neg_next;
    logic [QCNT_W-1:0]         qcnt_reg, qcnt_next;
    tpl_link_t                 link_reg, link_next;

    logic [NIDX_W-1:0]         rd_idx;
    logic signed [VALUE_W-1:0] w_rd;
    logic [PROD_W-1:0]         mag;
    logic [WIN_W:0]            trial;
    logic signed [DELTA_W-1:0] delta;
    logic signed [NEWW_W-1:0]  neww;
    logic signed [VALUE_W-1:0] w_sat;

    // One read port: the chain uses it when idle, the update unit otherwise
    assign rd_idx = (state_reg == CS_IDLE) ? link_in.idx : nidx_reg;
    assign w_rd   = w_reg[rd_idx];
    assign busy   = (state_reg != CS_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE:  if (ctl.upd_start) state_next = CS_SCALE;
            CS_SCALE: state_next = CS_MUL;
            CS_MUL:   state_next = CS_MAG;
            CS_MAG:   state_next = CS_DIV;
            CS_DIV:   if (qcnt_reg == QCNT_W'(QUO_W - 1)) state_next = CS_APPLY;
            CS_APPLY:
            begin
                if (nidx_reg == NIDX_W'(NEURONS - 1))
                    state_next = CS_IDLE;
                else
                    state_next = CS_MUL;
            end
            default:  state_next = CS_IDLE;
        endcase
    end

    always_comb
    begin
        nidx_next = nidx_reg;
        gain_next = gain_reg;
        prod_next = prod_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        qcnt_next = qcnt_reg;
        mag       = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
        trial     = {rem_reg, quo_reg[QUO_W-1]};
        delta     = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
        neww      = NEWW_W'(w_rd) + NEWW_W'(delta);
        // Saturate when the top bits do not all agree with the sign
        if ((&neww[NEWW_W-1:VALUE_W-1]) || !(|neww[NEWW_W-1:VALUE_W-1]))
            w_sat = neww[VALUE_W-1:0];
        else if (neww[NEWW_W-1])
            w_sat = {1'b1, {(VALUE_W-1){1'b0}}};
        else
            w_sat = {1'b0, {(VALUE_W-1){1'b1}}};

        unique case (state_reg)
            CS_IDLE: ;
            CS_SCALE:
            begin
                gain_next = GAIN_W'(count_reg) * GAIN_W'(ctl.rate);
                nidx_next = '0;
            end
            CS_MUL:
            begin
                prod_next = w_rd * $signed({1'b0, gain_reg});
            end
            CS_MAG:
            begin
                neg_next  = prod_reg[PROD_W-1];
                quo_next  = mag[PROD_W-2:FRAC_W];
                rem_next  = '0;
                qcnt_next = '0;
            end
            CS_DIV:
            begin
                // Restoring division by the window, one quotient bit a cycle
                if (trial >= {1'b0, ctl.win})
                begin
                    rem_next = WIN_W'(trial - {1'b0, ctl.win});
                    quo_next = {quo_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[WIN_W-1:0];
                    quo_next = {quo_reg[QUO_W-2:0], 1'b0};
                end
                qcnt_next = qcnt_reg + QCNT_W'(1);
            end
            CS_APPLY:
            begin
                nidx_next = nidx_reg + NIDX_W'(1);
            end
            default: ;
        endcase

        link_next.valid = link_in.valid;
        link_next.idx   = link_in.idx;
        link_next.sum   = (link_in.valid && sig_reg) ? link_in.sum + SUM_W'(w_rd)
                                                     : link_in.sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
            count_reg <= '0;
            sig_reg   <= 1'b0;
            nidx_reg  <= '0;
            qcnt_reg  <= '0;
            link_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            nidx_reg  <= nidx_next;
            qcnt_reg  <= qcnt_next;
            link_reg  <= link_next;
            if (ctl.clear)
                count_reg <= '0;
            else if (ctl.count_en && sig && (count_reg != COUNT_MAX))
                count_reg <= count_reg + COUNT_W'(1);
            if (ctl.count_en)
                sig_reg <= sig;
        end
    end

    always_ff @(posedge clk)
    begin
        gain_reg <= gain_next;
        prod_reg <= prod_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        if (ctl.load_en && wsel)
            w_reg[ctl.load_neuron] <= ctl.load_value;
        else if (state_reg == CS_APPLY)
            w_reg[nidx_reg] <= w_sat;
    end

    assign link_out = link_reg;

endmodule

// File: hdl/threshold_perceptron_layer_core.sv
// ---------------------------------------------------------------------------
// threshold_perceptron_layer_core
// Layer of threshold neurons built as a row of per-line cells.
// ---------------------------------------------------------------------------
// Usage:
//   cmd carries items: load weight, load threshold or time step. res returns
//   one item (fired bits, weights_updated) for every step item; loads give none.
//   A load leaves the block idle, and it is ready again on the next cycle.
//   In a step without update the neurons enter the cell row one a cycle and
//   each partial sum crosses LINES cells on its way to the result.
//   A step that strengthens the weights first runs the serial update in every
//   cell in parallel, through the 41-step restoring divider of each cell (one
//   quotient bit a cycle) for each neuron in turn.
//   Weights and thresholds must all be loaded before the first step.
//   Reset clears the counts, the phase and the result valid flag; weights and
//   thresholds stay undefined until loaded. A result waits in an output
//   register; while it is stalled the block takes loads and starts the next
//   step, and holds that step's result until the register is free.
//   wr_en / wr_index / wr_data write window_length and learning_rate. Write
//   them only when idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module threshold_perceptron_layer_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    tpl_cmd_if.sink                         cmd,
    tpl_res_if.source                       res,
    input  logic                            wr_en,
    input  logic [tpl_pkg::REG_IDX_W-1:0]   wr_index,
    input  logic [tpl_pkg::CFG_W-1:0]       wr_data
);
    import tpl_pkg::*;

    state_t                    state_reg, state_next;
    logic [WIN_W-1:0]          window_reg;
    logic [RATE_W-1:0]         rate_reg;
    logic [WIN_W-1:0]          phase_reg;
    logic                      seen_reg;
    logic                      upd_reg;
    logic signed [VALUE_W-1:0] thr_reg [NEURONS];
    logic [NIDX_W-1:0]         inj_reg;
    logic [ACC_W-1:0]          acc_reg;
    logic                      res_valid_reg;
    logic [FIRED_W-1:0]        res_fired_reg;
    logic                      res_upd_reg;

    logic                      accept, step_acc, update_now, cells_busy, tail_last;
    logic                      res_load;
    logic [WIN_W-1:0]          win_eff;
    logic [WIN_W:0]            phase_inc;
    logic [LINES-1:0]          busy;
    logic [LINES-1:0]          wsel;
    logic [LINES-1:0]          sig;
    tpl_ctl_t                  ctl;
    tpl_link_t                 links [LINES+1];
    logic signed [THR_W-1:0]   tail_sum, tail_thr;

    assign accept     = cmd.valid && cmd.ready;
    assign step_acc   = accept && (opcode_t'(cmd.opcode) == OP_STEP);
    assign update_now = seen_reg && (phase_reg == '0);
    assign win_eff    = (window_reg == '0) ? WIN_W'(1) : window_reg;
    assign phase_inc  = {1'b0, phase_reg} + (WIN_W+1)'(1);
    assign cells_busy = |busy;
    assign tail_last  = links[LINES].valid && (links[LINES].idx == NIDX_W'(NEURONS - 1));
    assign res_load   = (state_reg == ST_OUT) && (!res_valid_reg || res.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (step_acc) state_next = update_now ? ST_UPD_GO : ST_SUM;
            ST_UPD_GO:   state_next = ST_UPD_WAIT;
            ST_UPD_WAIT: if (!cells_busy) state_next = ST_SUM;
            ST_SUM:      if (inj_reg == NIDX_W'(NEURONS - 1)) state_next = ST_DRAIN;
            ST_DRAIN:    if (tail_last) state_next = ST_OUT;
            ST_OUT:      if (res_load) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.ready       = 1'b0;
        ctl.count_en    = step_acc;
        ctl.clear       = 1'b0;
        ctl.upd_start   = 1'b0;
        ctl.load_en     = 1'b0;
        ctl.load_neuron = cmd.neuron_index[NIDX_W-1:0];
        ctl.load_value  = cmd.load_value;
        ctl.win         = win_eff;
        ctl.rate        = rate_reg;
        links[0].valid  = 1'b0;
        links[0].idx    = inj_reg;
        links[0].sum    = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.ready   = 1'b1;
                ctl.load_en = accept && (opcode_t'(cmd.opcode) == OP_LOAD_WEIGHT)
                              && (int'(cmd.neuron_index) < NEURONS);
            end
            ST_UPD_GO:   ctl.upd_start = 1'b1;
            ST_UPD_WAIT: ctl.clear = !cells_busy;
            ST_SUM:      links[0].valid = 1'b1;
            ST_DRAIN: ;
            ST_OUT: ;
            default: ;
        endcase
    end

    generate
        for (genvar k = 0; k < LINES; k++)
        begin : g_cell
            if (k < SIG_W)
            begin : g_sig
                assign sig[k] = cmd.signals[k];
            end
            else
            begin : g_nosig
                assign sig[k] = 1'b0;
            end
            assign wsel[k] = (int'(cmd.line_index) == k);

            tpl_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .wsel     (wsel[k]),
                .sig      (sig[k]),
                .link_in  (links[k]),
                .link_out (links[k+1]),
                .busy     (busy[k])
            );
        end
    endgenerate

    assign tail_sum = THR_W'(links[LINES].sum);
    assign tail_thr = {thr_reg[links[LINES].idx], {FRAC_W{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            window_reg    <= WINDOW_RESET;
            rate_reg      <= RATE_RESET;
            phase_reg     <= '0;
            seen_reg      <= 1'b0;
            upd_reg       <= 1'b0;
            inj_reg       <= '0;
            acc_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
            begin
                unique case (wr_index)
                    REG_WINDOW: window_reg <= wr_data[WIN_W-1:0];
                    REG_RATE:   rate_reg   <= wr_data[RATE_W-1:0];
                    default: ;
                endcase
            end
            if (step_acc)
            begin
                upd_reg   <= update_now;
                seen_reg  <= 1'b1;
                acc_reg   <= '0;
                inj_reg   <= '0;
                // Wrap when the phase reaches or passes the window
                phase_reg <= (phase_inc >= {1'b0, win_eff}) ? '0 : phase_inc[WIN_W-1:0];
            end
            else
            begin
                if (state_reg == ST_SUM)
                    inj_reg <= inj_reg + NIDX_W'(1);
                if (links[LINES].valid && (tail_sum >= tail_thr))
                    acc_reg[links[LINES].idx] <= 1'b1;
            end
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (res.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (state_reg == ST_IDLE) &&
            (opcode_t'(cmd.opcode) == OP_LOAD_THRESHOLD) &&
            (int'(cmd.neuron_index) < NEURONS))
            thr_reg[cmd.neuron_index[NIDX_W-1:0]] <= cmd.load_value;
        if (res_load)
        begin
            res_fired_reg <= acc_reg[FIRED_W-1:0];
            res_upd_reg   <= upd_reg;
        end
    end

    assign res.valid           = res_valid_reg;
    assign res.fired           = res_fired_reg;
    assign res.weights_updated = res_upd_reg;

endmodule

// File: hdl/tpl_checker.sv
// ---------------------------------------------------------------------------
// tpl_checker
// Port-level checks of the perceptron layer, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tpl_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        cmd_valid,
    input logic                        cmd_ready,
    input logic [tpl_pkg::OP_W-1:0]    cmd_opcode,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic [tpl_pkg::FIRED_W-1:0] res_fired,
    input logic                        res_updated
);
    import tpl_pkg::*;

    logic step_acc, load_acc;

    assign step_acc = cmd_valid && cmd_ready && (cmd_opcode == OP_STEP);
    assign load_acc = cmd_valid && cmd_ready && (cmd_opcode != OP_STEP);

    // A stalled result item must hold
    `TPL_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(res_fired) && $stable(res_updated))
    // A step keeps the block busy on the following cycle
    `TPL_ASSERT(a_step_busy, step_acc |=> !cmd_ready)
    // Loads and ignored items leave the block ready on the following cycle
    `TPL_ASSERT(a_load_quick, load_acc |=> cmd_ready)

endmodule

bind threshold_perceptron_layer_core tpl_checker u_tpl_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .cmd_opcode  (cmd.opcode),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .res_fired   (res.fired),
    .res_updated (res.weights_updated)
);

// File: tb/sv/threshold_perceptron_layer_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// threshold_perceptron_layer_core_test
// Drives load and step items into the perceptron layer with random gaps and
// output stalls, predicts fired bits and update flags in a local copy of the
// layer, and compares every result item against the oldest prediction.
// ---------------------------------------------------------------------------
module threshold_perceptron_layer_core_test;
    import tpl_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int              CYCLE_LIMIT = 1000000;
    localparam int              DRAIN_CYCLES = 240;

    typedef struct {
        logic [FIRED_W-1:0] fired;
        logic               updated;
    } layer_out_t;

    logic clk;
    logic rst_n;
    logic wr_en;
    logic [REG_IDX_W-1:0] wr_index;
    logic [CFG_W-1:0] wr_data;

    tpl_cmd_if cmd_ch();
    tpl_res_if res_ch();

    threshold_perceptron_layer_core uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd_ch),
        .res      (res_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // local copy of the layer
    int         win_reg;
    int         rate_reg;
    int         weight_mem [NEURONS*LINES];
    int         thr_mem [NEURONS];
    int         line_ones [LINES];
    int         phase;
    bit         stepped;
    layer_out_t expected_q [$];

    int  mismatches;
    int  cycles;
    bit  stall_en;
    bit  gap_en;
    int  stall_left;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("threshold_perceptron_layer_core_test: done, errors");
            $finish;
        end
    end

    // output back-pressure: mostly short stalls, now and then a long one
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            res_ch.ready <= 1'b0;
        end
        else if (stall_en && $urandom_range(0, 3) == 0)
        begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 3);
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        layer_out_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: fired=%h updated=%b",
                             res_ch.fired, res_ch.weights_updated);
            end
            else
            begin
                want = expected_q.pop_front();
                if (res_ch.fired !== want.fired || res_ch.weights_updated !== want.updated)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: fired exp %h got %h, updated exp %b got %b",
                                 want.fired, res_ch.fired, want.updated,
                                 res_ch.weights_updated);
                end
            end
        end
    end

    function automatic int strengthened(int w, int ones, int win);
        longint num;
        longint den;
        longint nw;
        num = longint'(w) * longint'(ones) * longint'(rate_reg);
        den = longint'(win) * 65536;
        nw = longint'(w) + num / den;
        if (nw > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (nw < -64'sd2147483648)
            return 32'sh80000000;
        return int'(nw);
    endfunction

    function automatic void predict_layer(logic [OP_W-1:0] op, int ni, int li, int val,
                                          logic [SIG_W-1:0] sig);
        int         win;
        longint     acc;
        layer_out_t r;
        case (op)
            OP_LOAD_WEIGHT:
                if (ni < NEURONS && li < LINES)
                    weight_mem[ni*LINES+li] = val;
            OP_LOAD_THRESHOLD:
                if (ni < NEURONS)
                    thr_mem[ni] = val;
            OP_STEP:
            begin
                win = (win_reg == 0) ? 1 : win_reg;
                for (int k = 0; k < LINES; k++)
                    if (k < SIG_W && sig[k] && line_ones[k] < COUNT_MAX)
                        line_ones[k]++;
                r.updated = stepped && phase == 0;
                if (r.updated)
                begin
                    for (int j = 0; j < NEURONS; j++)
                        for (int k = 0; k < LINES; k++)
                            weight_mem[j*LINES+k] =
                                strengthened(weight_mem[j*LINES+k], line_ones[k], win);
                    for (int k = 0; k < LINES; k++)
                        line_ones[k] = 0;
                end
                r.fired = '0;
                for (int j = 0; j < NEURONS; j++)
                begin
                    acc = 0;
                    for (int k = 0; k < LINES && k < SIG_W; k++)
                        if (sig[k])
                            acc += longint'(weight_mem[j*LINES+k]);
                    if (acc >= longint'(thr_mem[j]) * 65536 && j < FIRED_W)
                        r.fired[j] = 1'b1;
                end
                stepped = 1'b1;
                phase = (phase + 1 >= win) ? 0 : ((phase + 1) & 8'hFF);
                expected_q.push_back(r);
            end
            default:
                ;
        endcase
    endfunction

    task automatic send_item(logic [OP_W-1:0] op, int ni, int li, int val,
                             logic [SIG_W-1:0] sig);
        int gap;
        gap = 0;
        if (gap_en && $urandom_range(0, 2) == 0)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.opcode       <= op;
        cmd_ch.neuron_index <= ni[NIDX_IN_W-1:0];
        cmd_ch.line_index   <= li[LIDX_IN_W-1:0];
        cmd_ch.load_value   <= val;
        cmd_ch.signals      <= sig;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        predict_layer(op, ni, li, val, sig);
    endtask

    task automatic send_step(logic [SIG_W-1:0] sig);
        send_item(OP_STEP, $urandom_range(0, 15), $urandom_range(0, 31), $urandom, sig);
    endtask

    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, int value);
        wait_drained();
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value[CFG_W-1:0];
        @(posedge clk);
        wr_en <= 1'b0;
        if (idx == REG_WINDOW)
            win_reg = value & 8'hFF;
        else
            rate_reg = value & 16'hFFFF;
    endtask

    function automatic int pick_weight();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2, 3: return $urandom;
            default: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
        endcase
    endfunction

    function automatic int pick_threshold();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return ($urandom_range(0, 1) != 0) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return $signed($urandom_range(0, 16)) - 8;
        endcase
    endfunction

    task automatic load_layer(bit extremes);
        for (int j = 0; j < NEURONS; j++)
        begin
            for (int k = 0; k < LINES; k++)
                send_item(OP_LOAD_WEIGHT, j, k,
                          extremes ? ((j + k) % 2 ? 32'sh7FFFFFFF : 32'sh80000000)
                                   : pick_weight(),
                          $urandom);
            send_item(OP_LOAD_THRESHOLD, j, $urandom_range(0, 31),
                      extremes ? (j % 2 ? 32'sh7FFFFFFF : 32'sh80000000) : pick_threshold(),
                      $urandom);
        end
    endtask

    // loads outside the layer and the spare opcode must leave it untouched
    task automatic send_noise();
        case ($urandom_range(0, 2))
            0: send_item(OP_LOAD_WEIGHT, $urandom_range(NEURONS, 15), $urandom_range(0, 31),
                         $urandom, $urandom);
            1: send_item(OP_LOAD_WEIGHT, $urandom_range(0, 15), $urandom_range(LINES, 31),
                         $urandom, $urandom);
            default: send_item(($urandom_range(0, 1) != 0) ? OP_UNUSED : OP_LOAD_THRESHOLD,
                               $urandom_range(NEURONS, 15), $urandom_range(0, 31),
                               $urandom, $urandom);
        endcase
    endtask

    task automatic test_directed();
        load_layer(1'b1);
        send_step(8'h00);
        send_step(8'hFF);
        send_step(8'h55);
        send_step(8'hAA);
        send_step(8'h01);
        send_step(8'h80);
        send_item(OP_LOAD_WEIGHT, 15, 31, 32'sh7FFFFFFF, 8'hFF);
        send_item(OP_LOAD_WEIGHT, 0, 31, 32'sh80000000, 8'hFF);
        send_item(OP_LOAD_THRESHOLD, 15, 0, 0, 8'h00);
        send_item(OP_UNUSED, 15, 31, $urandom, 8'hFF);
        send_step(8'hFF);
        load_layer(1'b0);
        send_step(8'hC3);
    endtask

    task automatic test_window_extremes();
        write_reg(REG_WINDOW, 1);
        write_reg(REG_RATE, 16'hFFFF);
        for (int i = 0; i < 6; i++)
            send_step($urandom);
        write_reg(REG_WINDOW, 0);
        write_reg(REG_RATE, 0);
        for (int i = 0; i < 3; i++)
            send_step($urandom);
        load_layer(1'b0);
        write_reg(REG_WINDOW, 255);
        write_reg(REG_RATE, 16'hFFFF);
        for (int i = 0; i < 260; i++)
            send_step(($urandom_range(0, 3) != 0) ? 8'hFF : 8'($urandom));
    endtask

    task automatic test_window_shrink();
        load_layer(1'b0);
        write_reg(REG_WINDOW, 200);
        for (int i = 0; i < 10; i++)
            send_step($urandom);
        // phase is past the new window, so it must wrap
        write_reg(REG_WINDOW, 3);
        for (int i = 0; i < 8; i++)
            send_step($urandom);
    endtask

    task automatic test_random();
        for (int p = 0; p < 6; p++)
        begin
            stall_en = (p != 2);
            gap_en   = (p != 2);
            write_reg(REG_WINDOW, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                             : $urandom_range(1, 8));
            write_reg(REG_RATE, ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535)
                                                           : $urandom_range(0, 4000));
            if (p % 2 == 0)
                load_layer(1'b0);
            for (int i = 0; i < 60; i++)
            begin
                case ($urandom_range(0, 9))
                    0, 1: send_item(OP_LOAD_WEIGHT, $urandom_range(0, NEURONS - 1),
                                    $urandom_range(0, LINES - 1), pick_weight(), $urandom);
                    2: send_item(OP_LOAD_THRESHOLD, $urandom_range(0, NEURONS - 1),
                                 $urandom_range(0, 31), pick_threshold(), $urandom);
                    3: send_noise();
                    default: send_step($urandom);
                endcase
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.opcode = OP_STEP;
        cmd_ch.neuron_index = '0;
        cmd_ch.line_index = '0;
        cmd_ch.load_value = '0;
        cmd_ch.signals = '0;
        res_ch.ready = 1'b0;
        cycles = 0;
        mismatches = 0;
        stall_left = 0;
        stall_en = 1'b1;
        gap_en = 1'b1;
        win_reg = WINDOW_RESET;
        rate_reg = RATE_RESET;
        phase = 0;
        stepped = 1'b0;
        for (int i = 0; i < NEURONS*LINES; i++)
            weight_mem[i] = 0;
        for (int i = 0; i < NEURONS; i++)
            thr_mem[i] = 0;
        for (int i = 0; i < LINES; i++)
            line_ones[i] = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_window_extremes();
        test_window_shrink();
        test_random();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("threshold_perceptron_layer_core_test: done, clean");
        else
            $display("threshold_perceptron_layer_core_test: done, errors");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/tpl_pkg.sv
hdl/tpl_channels.sv
hdl/tpl_cell.sv
hdl/threshold_perceptron_layer_core.sv
hdl/tpl_checker.sv
tb/sv/threshold_perceptron_layer_core_test.sv
